// ===== rtl/core/fxa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU core: word sizes, operation codes,
// and the input and result beat structs. It depends on nothing.
package fxa_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 8;

    // Restoring divider: dividend is |a| << FRACTION_BITS.
    localparam int DIV_BITS   = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_TOTAL  = DIV_STAGES * DIV_STEPS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_CMP      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_FROM_INT = 4'd9,
        OP_TO_INT   = 4'd10
    } t_op;

    typedef struct packed {
        logic [3:0]                  operation;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        less_flag;
        logic                        equal_flag;
        logic                        greater_flag;
        logic                        divide_by_zero;
    } t_out_beat;

endpackage

// ===== rtl/core/fxa_div.sv =====
// Pipelined restoring divider for the fixed-point ALU: unsigned magnitudes,
// DIV_STEPS quotient bits per stage. Depends on fxa_pkg.
module fxa_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [fxa_pkg::WORD_BITS-1:0]   i_num,
    input  logic [fxa_pkg::WORD_BITS-1:0]   i_den,
    output logic [fxa_pkg::WORD_BITS-1:0]   o_quo
);

    localparam int W  = fxa_pkg::WORD_BITS;
    localparam int T  = fxa_pkg::DIV_TOTAL;
    localparam int DS = fxa_pkg::DIV_STAGES;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [T-1:0] num;
        logic [W-1:0] den;
    } t_div_st;

    function automatic t_div_st div_steps(t_div_st s);
        t_div_st    r;
        logic [W:0] trial;
        r = s;
        for (int k = 0; k < fxa_pkg::DIV_STEPS; k++) begin
            trial = {r.rem, r.num[T-1]};
            r.num = {r.num[T-2:0], 1'b0};
            if (trial >= {1'b0, r.den}) begin
                r.rem    = W'(trial - {1'b0, r.den});
                r.num[0] = 1'b1;
            end else begin
                r.rem = trial[W-1:0];
            end
        end
        return r;
    endfunction

    t_div_st r_st [DS];
    t_div_st w_first;

    // quotient replaces the dividend bit by bit; leading pad bits are zero
    assign w_first = '{rem: '0,
                       num: T'({i_num, {fxa_pkg::FRACTION_BITS{1'b0}}}),
                       den: i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_steps(w_first);
            for (int s = 1; s < DS; s++) begin
                r_st[s] <= div_steps(r_st[s-1]);
            end
        end
    end

    assign o_quo = r_st[DS-1].num[W-1:0];

endmodule

// ===== rtl/core/fixed_point_alu_q24_8_core.sv =====
// Top level of the Q24.8 fixed-point ALU: input register, compare/add/multiply
// logic beside the first divider stage, pipelined divider, output register.
// Depends on fxa_pkg and fxa_div.
//
//  channel | signals                         | dir | payload
//  --------+---------------------------------+-----+---------------------
//  in      | i_valid, o_stall, i_data        | in  | fxa_pkg::t_in_beat
//  out     | o_valid, i_stall, o_data        | out | fxa_pkg::t_out_beat
//
// One beat per cycle while the output is not stalled. The path runs through the
// input register, ten divider stages of four quotient bits, output register.
// Every operation takes the same path so beats stay in order.
// Reset clears only the valid bits; the input is stalled while reset is low.
// A stall while the output beat is valid freezes the whole pipeline, bubbles
// included, so nothing is lost or repeated.
module fixed_point_alu_q24_8_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fxa_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output fxa_pkg::t_out_beat  o_data
);

    localparam int W  = fxa_pkg::WORD_BITS;
    localparam int F  = fxa_pkg::FRACTION_BITS;
    localparam int DS = fxa_pkg::DIV_STAGES;

    // side data that rides alongside the divider
    typedef struct packed {
        logic [3:0]   op;
        logic [W-1:0] result;
        logic         lt;
        logic         eq;
        logic         gt;
        logic         dz;
        logic         neg;
    } t_side;

    logic               w_en;
    logic               r_v0;
    fxa_pkg::t_in_beat  r_s0;
    logic [DS-1:0]      r_vs;
    t_side              r_side [DS];
    logic               r_out_valid;
    fxa_pkg::t_out_beat r_out;

    logic signed [W-1:0]   w_a, w_b;
    logic signed [2*W-1:0] w_prod;
    logic [W-1:0]          w_ua, w_ub, w_quo, w_res;
    t_side                 w_side;
    fxa_pkg::t_out_beat    n_out;

    // whole pipe advances unless the output beat is held
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_vs        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v0        <= i_valid;
            r_vs        <= {r_vs[DS-2:0], r_v0};
            r_out_valid <= r_vs[DS-1];
        end
    end

    // stage 0 -> 1: everything but the divide finishes here
    assign w_a    = r_s0.operand_a;
    assign w_b    = r_s0.operand_b;
    assign w_prod = w_a * w_b;
    assign w_ua   = w_a[W-1] ? W'(-w_a) : w_a;
    assign w_ub   = w_b[W-1] ? W'(-w_b) : w_b;

    always_comb begin
        w_side     = '0;
        w_side.op  = r_s0.operation;
        w_side.lt  = (w_a < w_b);
        w_side.eq  = (w_a == w_b);
        w_side.gt  = (w_a > w_b);
        w_side.dz  = (r_s0.operation == fxa_pkg::OP_DIV) && (w_b == '0);
        w_side.neg = w_a[W-1] ^ w_b[W-1];
        unique case (r_s0.operation)
            fxa_pkg::OP_ADD:      w_side.result = W'(w_a + w_b);
            fxa_pkg::OP_SUB:      w_side.result = W'(w_a - w_b);
            fxa_pkg::OP_MUL:      w_side.result = w_prod[F+W-1:F];
            fxa_pkg::OP_MIN:      w_side.result = (w_a > w_b) ? w_b : w_a;
            fxa_pkg::OP_MAX:      w_side.result = (w_a < w_b) ? w_b : w_a;
            fxa_pkg::OP_INC:      w_side.result = W'(w_a + 1);
            fxa_pkg::OP_DEC:      w_side.result = W'(w_a - 1);
            fxa_pkg::OP_FROM_INT: w_side.result = {w_a[W-F-1:0], {F{1'b0}}};
            fxa_pkg::OP_TO_INT:   w_side.result = W'(w_a >>> F);
            default:              w_side.result = '0; // div, compare, unused
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0      <= i_data;
            r_side[0] <= w_side;
            for (int s = 1; s < DS; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_out     <= n_out;
        end
    end

    fxa_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_ua),
        .i_den (w_ub),
        .o_quo (w_quo)
    );

    // final select; quotient sign applied after truncation to the word
    always_comb begin
        if (r_side[DS-1].op == fxa_pkg::OP_DIV) begin
            if (r_side[DS-1].dz) begin
                w_res = '0;
            end else begin
                w_res = r_side[DS-1].neg ? W'(-w_quo) : w_quo;
            end
        end else begin
            w_res = r_side[DS-1].result;
        end
        n_out.result_value   = w_res;
        n_out.less_flag      = r_side[DS-1].lt;
        n_out.equal_flag     = r_side[DS-1].eq;
        n_out.greater_flag   = r_side[DS-1].gt;
        n_out.divide_by_zero = r_side[DS-1].dz;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== sim/testbench.sv =====
// Testbench for fixed_point_alu_q24_8_core: directed table, then random beats,
// each result checked against an in-bench Q24.8 predictor. Depends on fxa_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY     = fxa_pkg::DIV_STAGES + 2;
    localparam int N_RANDOM    = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int FB          = fxa_pkg::FRACTION_BITS;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    fxa_pkg::t_in_beat  i_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    fxa_pkg::t_out_beat o_data;

    // One row of the directed table: check_value set when the result is typed in.
    typedef struct {
        fxa_pkg::t_in_beat  beat;
        bit                 check_value;
        fxa_pkg::t_out_beat want;
    } t_row;

    fxa_pkg::t_out_beat alu_results_q[$];
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 stim_done = 1'b0;

    fixed_point_alu_q24_8_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #10 i_clk = ~i_clk;

    // Q24.8 predictor: full 64-bit product and widened dividend, then wrap.
    function automatic fxa_pkg::t_out_beat alu_predict(fxa_pkg::t_in_beat b);
        fxa_pkg::t_out_beat r;
        logic signed [31:0] a, d;
        logic signed [63:0] prod;
        logic signed [71:0] num, quo;
        a = b.operand_a;
        d = b.operand_b;
        r = '0;
        r.less_flag    = a < d;
        r.equal_flag   = a == d;
        r.greater_flag = a > d;
        case (b.operation)
            fxa_pkg::OP_ADD: r.result_value = a + d;
            fxa_pkg::OP_SUB: r.result_value = a - d;
            fxa_pkg::OP_MUL: begin
                prod = 64'(a) * 64'(d);
                r.result_value = 32'(prod >>> FB);
            end
            fxa_pkg::OP_DIV: begin
                if (d == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    num = 72'(a) <<< FB;
                    quo = num / 72'(d);   // signed division truncates toward zero
                    r.result_value = 32'(quo);
                end
            end
            fxa_pkg::OP_MIN:      r.result_value = (a > d) ? d : a;
            fxa_pkg::OP_MAX:      r.result_value = (a < d) ? d : a;
            fxa_pkg::OP_INC:      r.result_value = a + 1;
            fxa_pkg::OP_DEC:      r.result_value = a - 1;
            fxa_pkg::OP_FROM_INT: r.result_value = a <<< FB;
            fxa_pkg::OP_TO_INT:   r.result_value = a >>> FB;
            default:              r.result_value = '0;   // compare and unused codes
        endcase
        return r;
    endfunction

    // Sender: present one beat, hold until accepted, then gap.
    task automatic send_beat(fxa_pkg::t_in_beat b);
        int gap;
        i_data  <= b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        alu_results_q.push_back(alu_predict(b));
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic fxa_pkg::t_in_beat rand_beat();
        fxa_pkg::t_in_beat b;
        logic [31:0] pick [8];
        pick = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h100, 32'hFFFF_FF00, 32'h0};
        b.operation = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                    : 4'($urandom_range(0, 10));
        case ($urandom_range(0, 3))
            0: b.operand_a = pick[$urandom_range(0, 7)];
            1: b.operand_a = $signed(32'($urandom_range(0, 4095))) - 2048;
            default: b.operand_a = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: b.operand_b = pick[$urandom_range(0, 7)];
            1: b.operand_b = $signed(32'($urandom_range(0, 4095))) - 2048;
            2: b.operand_b = b.operand_a;   // hit the equal flag
            default: b.operand_b = $urandom;
        endcase
        return b;
    endfunction

    // Directed rows; expected values typed in for the obvious ones.
    t_row table_rows [] = '{
        '{'{fxa_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh1}, 1'b1,
          '{32'sh8000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{fxa_pkg::OP_SUB, 32'sh8000_0000, 32'sh1}, 1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_MUL, 32'sh100, 32'sh100}, 1'b1,
          '{32'sh100, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0},
        '{'{fxa_pkg::OP_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0, '0},
        '{'{fxa_pkg::OP_DIV, 32'sh500, 32'sh0}, 1'b1,
          '{32'sh0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{fxa_pkg::OP_DIV, 32'sh0, 32'sh0}, 1'b1,
          '{32'sh0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{fxa_pkg::OP_DIV, 32'sh8000_0000, 32'shFFFF_FFFF}, 1'b0, '0},
        '{'{fxa_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh1}, 1'b0, '0},
        '{'{fxa_pkg::OP_DIV, -32'sh300, 32'sh200}, 1'b0, '0},
        '{'{fxa_pkg::OP_MIN, 32'sh5, 32'sh3}, 1'b1,
          '{32'sh3, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{fxa_pkg::OP_MIN, 32'sh3, 32'sh3}, 1'b1,
          '{32'sh3, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_CMP, 32'sh1, 32'sh2}, 1'b1,
          '{32'sh0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_INC, 32'sh7FFF_FFFF, 32'sh0}, 1'b1,
          '{32'sh8000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{fxa_pkg::OP_DEC, 32'sh8000_0000, 32'sh0}, 1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_FROM_INT, 32'sh7FFF_FFFF, 32'sh0}, 1'b1,
          '{32'shFFFF_FF00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{fxa_pkg::OP_TO_INT, 32'sh8000_0000, 32'sh0}, 1'b1,
          '{32'shFF80_0000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fxa_pkg::OP_TO_INT, -32'sh1, 32'sh0}, 1'b1,
          '{-32'sh1, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{4'd11, 32'sh4, 32'sh4}, 1'b1,
          '{32'sh0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{4'd15, 32'shFFFF_FFFF, 32'sh0}, 1'b1,
          '{32'sh0, 1'b1, 1'b0, 1'b0, 1'b0}}
    };

    // Stimulus process.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[k]) begin
            if (table_rows[k].check_value &&
                alu_predict(table_rows[k].beat) != table_rows[k].want) begin
                $display("%0t table row %0d: expected %h actual %h", $time, k,
                         table_rows[k].want, alu_predict(table_rows[k].beat));
                fail_count++;
            end
            send_beat(table_rows[k].beat);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            // hold off once mid-run until the pipeline drains
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (alu_results_q.size() != 0) @(posedge i_clk);
            end
            send_beat(rand_beat());
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall per beat, compare every accepted result.
    initial begin
        fxa_pkg::t_out_beat want;
        int                 hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (alu_results_q.size() == 0) begin
                    $display("%0t unexpected beat: actual %h", $time, o_data);
                    fail_count++;
                end else begin
                    want = alu_results_q.pop_front();
                    if (o_data.result_value !== want.result_value ||
                        o_data.less_flag !== want.less_flag ||
                        o_data.equal_flag !== want.equal_flag ||
                        o_data.greater_flag !== want.greater_flag ||
                        o_data.divide_by_zero !== want.divide_by_zero) begin
                        $display("%0t mismatch: expected %h actual %h",
                                 $time, want, o_data);
                        fail_count++;
                    end
                end
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Run end and watchdog.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
            if (stim_done && alu_results_q.size() == 0) begin
                repeat (LATENCY + 16) @(posedge i_clk);
                if (fail_count == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
